// ===== src/aip_pkg.sv =====
`timescale 1ns / 1ps

package aip_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_OFFSET  = 255;
  localparam int OFFSET_BITS = $clog2(MAX_OFFSET + 1);
  localparam int BASE_BITS   = 6;
  localparam int CHAR_BITS   = 8;
  localparam int MAC_BITS    = VALUE_BITS + BASE_BITS;

  localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
  localparam logic [BASE_BITS-1:0] BASE_TEN   = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = OFFSET_BITS'(MAX_OFFSET);

  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

  localparam logic [CHAR_BITS-1:0] DIGIT_NONE = 8'hFF;
  localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } phase_e;

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 start_of_string;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   wrapped;
  } res_t;

  // digit weight of a character, DIGIT_NONE when it is no digit or letter
  function automatic logic [CHAR_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + LETTER_OFS;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + LETTER_OFS;
    end
    return d;
  endfunction

endpackage

// ===== src/aip_in_reg.sv =====
`timescale 1ns / 1ps

module aip_in_reg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [aip_pkg::CHAR_BITS-1:0]    character_i,
  input  logic                             start_of_string_i,
  input  logic                             taken_i,
  output logic                             item_valid_o,
  output aip_pkg::in_item_t                item_o
);

  logic              valid_q, valid_d;
  aip_pkg::in_item_t item_q;
  logic              accept;

  assign in_ready_o = !valid_q || taken_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (taken_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.character       <= character_i;
      item_q.start_of_string <= start_of_string_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== src/aip_parse.sv =====
`timescale 1ns / 1ps

module aip_parse (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  input  aip_pkg::in_item_t                item_i,
  input  logic [aip_pkg::BASE_BITS-1:0]    number_base_i,
  input  logic                             out_free_i,
  output logic                             taken_o,
  output logic                             res_load_o,
  output aip_pkg::res_t                    res_o
);

  aip_pkg::phase_e                       phase_q, phase_d;
  logic [aip_pkg::VALUE_BITS-1:0]        acc_q, acc_d;
  logic                                  neg_q, neg_d;
  logic [aip_pkg::BASE_BITS-1:0]         base_q, base_d;
  logic [aip_pkg::OFFSET_BITS-1:0]       cnt_q, cnt_d;
  logic                                  wrap_q, wrap_d;

  // working copies after an optional restart
  aip_pkg::phase_e                       ph;
  logic [aip_pkg::VALUE_BITS-1:0]        acc;
  logic                                  neg;
  logic [aip_pkg::BASE_BITS-1:0]         base;
  logic [aip_pkg::OFFSET_BITS-1:0]       cnt;
  logic                                  wrap;
  logic [aip_pkg::CHAR_BITS-1:0]         c;
  logic [aip_pkg::CHAR_BITS-1:0]         dig;
  logic [aip_pkg::MAC_BITS-1:0]          mac;
  logic                                  go_signed, go_digit, bump, emit;

  always_comb begin
    c   = item_i.character;
    ph  = item_i.start_of_string ? aip_pkg::PH_LEAD : phase_q;
    acc = item_i.start_of_string ? '0 : acc_q;
    neg = item_i.start_of_string ? 1'b0 : neg_q;
    base = item_i.start_of_string ? number_base_i : base_q;
    cnt = item_i.start_of_string ? '0 : cnt_q;
    wrap = item_i.start_of_string ? 1'b0 : wrap_q;

    phase_d   = ph;
    acc_d     = acc;
    neg_d     = neg;
    base_d    = base;
    wrap_d    = wrap;
    go_signed = 1'b0;
    go_digit  = 1'b0;
    bump      = 1'b0;
    emit      = 1'b0;
    dig       = aip_pkg::digit_value(c);
    mac       = '0;

    unique case (ph)
      aip_pkg::PH_DONE: begin
      end
      aip_pkg::PH_LEAD: begin
        if (c == aip_pkg::CH_SPACE || c == aip_pkg::CH_TAB) begin
          bump = 1'b1;
        end else if (c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS) begin
          neg_d   = (c == aip_pkg::CH_MINUS);
          bump    = 1'b1;
          phase_d = aip_pkg::PH_SIGNED;
        end else begin
          go_signed = 1'b1;
        end
      end
      aip_pkg::PH_SIGNED: begin
        go_signed = 1'b1;
      end
      aip_pkg::PH_ZERO: begin
        if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
          base_d  = aip_pkg::BASE_HEX;
          bump    = 1'b1;
          phase_d = aip_pkg::PH_DIGITS;
        end else begin
          if (base == aip_pkg::BASE_AUTO) base_d = aip_pkg::BASE_TEN;
          go_digit = 1'b1;
        end
      end
      aip_pkg::PH_DIGITS: begin
        go_digit = 1'b1;
      end
      default: begin
      end
    endcase

    // sign taken or skipped: look for a leading zero of a hex prefix
    if (go_signed) begin
      if ((base == aip_pkg::BASE_AUTO || base == aip_pkg::BASE_HEX) &&
          c == aip_pkg::CH_ZERO) begin
        bump    = 1'b1;
        phase_d = aip_pkg::PH_ZERO;
      end else begin
        if (base == aip_pkg::BASE_AUTO) base_d = aip_pkg::BASE_TEN;
        go_digit = 1'b1;
      end
    end

    if (go_digit) begin
      phase_d = aip_pkg::PH_DIGITS;
      if (dig < {2'b00, base_d}) begin
        mac = aip_pkg::MAC_BITS'(acc) * aip_pkg::MAC_BITS'(base_d)
            + aip_pkg::MAC_BITS'(dig);
        acc_d = mac[aip_pkg::VALUE_BITS-1:0];
        if (|mac[aip_pkg::MAC_BITS-1:aip_pkg::VALUE_BITS]) wrap_d = 1'b1;
        bump = 1'b1;
      end else begin
        emit    = 1'b1;
        phase_d = aip_pkg::PH_DONE;
      end
    end

    cnt_d = (bump && cnt != aip_pkg::OFFSET_MAX) ? cnt + 1'b1 : cnt;

    res_o.value      = neg ? (~acc + 1'b1) : acc;
    res_o.end_offset = cnt;
    res_o.wrapped    = wrap;
  end

  // a terminating character waits only when the output register is full
  assign taken_o    = item_valid_i && (!emit || out_free_i);
  assign res_load_o = taken_o && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aip_pkg::PH_DONE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      base_q  <= aip_pkg::BASE_TEN;
      cnt_q   <= '0;
      wrap_q  <= 1'b0;
    end else if (taken_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      wrap_q  <= wrap_d;
    end
  end

endmodule

// ===== src/aip_out_reg.sv =====
`timescale 1ns / 1ps

module aip_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  aip_pkg::res_t res_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          out_free_o,
  output aip_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  aip_pkg::res_t res_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/ascii_integer_parser.sv =====
`timescale 1ns / 1ps

// ASCII to integer parser, strtol style, one character per transaction.
//
// Input channel (in_valid_i / in_ready_o): character_i plus start_of_string_i.
//   A transaction with the start flag set begins a new string at that
//   character; blanks, one sign, an optional 0x/0X prefix and digits follow.
// Output channel (out_valid_o / out_ready_i): one transaction per string, on
//   the first character that is not a digit of the base: value_o (signed,
//   modulo 2^32), end_offset_o (characters consumed, saturating) and
//   wrapped_o (magnitude overflowed 32 bits).
// Config channel (cfg_valid_i / cfg_ready_o): number_base_i, always ready,
//   latched into the running parse when a start character is processed.
//   Write it only while no string is in flight.
// Result path: the terminating character is held in the input register, then
//   its result is loaded into the result register, which drives out_valid_o.
// Throughput: one character per cycle unless a terminator waits; the path is
//   one 32x6 multiply-add and compare on the accumulator, input to result reg.
// Receiver stall: the result register holds its transaction; characters that
//   produce no result keep flowing, a terminating one waits in the input reg.
// Reset: no parse is active, base is ten, both registers empty.
module ascii_integer_parser (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [aip_pkg::BASE_BITS-1:0]         number_base_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [aip_pkg::CHAR_BITS-1:0]         character_i,
  input  logic                                  start_of_string_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [aip_pkg::VALUE_BITS-1:0] value_o,
  output logic [aip_pkg::OFFSET_BITS-1:0]       end_offset_o,
  output logic                                  wrapped_o
);

  logic [aip_pkg::BASE_BITS-1:0] number_base_q;

  logic              item_valid;
  aip_pkg::in_item_t item;
  logic              taken;
  logic              res_load;
  logic              out_free;
  aip_pkg::res_t     res_next;
  aip_pkg::res_t     res_out;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= aip_pkg::BASE_TEN;
    end else if (cfg_valid_i) begin
      number_base_q <= number_base_i;
    end
  end

  aip_in_reg u_aip_in_reg (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .character_i,
    .start_of_string_i,
    .taken_i      (taken),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  aip_parse u_aip_parse (
    .clk_i,
    .rst_ni,
    .item_valid_i  (item_valid),
    .item_i        (item),
    .number_base_i (number_base_q),
    .out_free_i    (out_free),
    .taken_o       (taken),
    .res_load_o    (res_load),
    .res_o         (res_next)
  );

  aip_out_reg u_aip_out_reg (
    .clk_i,
    .rst_ni,
    .load_i      (res_load),
    .res_i       (res_next),
    .out_ready_i,
    .out_valid_o,
    .out_free_o  (out_free),
    .res_o       (res_out)
  );

  assign value_o      = $signed(res_out.value);
  assign end_offset_o = res_out.end_offset;
  assign wrapped_o    = res_out.wrapped;

endmodule

// ===== src/aip_checker.sv =====
`timescale 1ns / 1ps

module aip_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  cfg_valid_i,
  input logic                                  cfg_ready_o,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [aip_pkg::VALUE_BITS-1:0] value_o,
  input logic [aip_pkg::OFFSET_BITS-1:0]       end_offset_o,
  input logic                                  wrapped_o
);

  // result stays offered while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(value_o) && $stable(end_offset_o) && $stable(wrapped_o))
    else $error("result payload changed while stalled");

  // an edge seen in reset leaves the result register empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // with room at the output the input side never stalls
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with a free output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  typedef logic [aip_pkg::CHAR_BITS-1:0] char_t;
  typedef logic [aip_pkg::BASE_BITS-1:0] radix_t;

  logic                                  clk_i;
  logic                                  rst_ni            = 1'b0;
  logic                                  cfg_valid_i       = 1'b0;
  logic                                  cfg_ready_o;
  radix_t                                number_base_i     = aip_pkg::BASE_TEN;
  logic                                  in_valid_i        = 1'b0;
  logic                                  in_ready_o;
  char_t                                 character_i       = '0;
  logic                                  start_of_string_i = 1'b0;
  logic                                  out_valid_o;
  logic                                  out_ready_i       = 1'b0;
  logic signed [aip_pkg::VALUE_BITS-1:0] value_o;
  logic [aip_pkg::OFFSET_BITS-1:0]       end_offset_o;
  logic                                  wrapped_o;

  ascii_integer_parser u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .number_base_i     (number_base_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .character_i       (character_i),
    .start_of_string_i (start_of_string_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .value_o           (value_o),
    .end_offset_o      (end_offset_o),
    .wrapped_o         (wrapped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop: far beyond the slowest legal run (long gaps and stalls on every transaction)
  initial begin
    #20_000_000;
    $display("ascii_integer_parser regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: base register copy plus the state of the running parse
  // ---------------------------------------------------------------------------
  radix_t                               radix_reg  = aip_pkg::BASE_TEN; // config port
  aip_pkg::phase_e                      p_phase    = aip_pkg::PH_DONE;
  logic [aip_pkg::VALUE_BITS-1:0]       p_acc      = '0;
  bit                                   p_negative = 1'b0;
  radix_t                               p_radix    = aip_pkg::BASE_TEN; // string start
  logic [aip_pkg::OFFSET_BITS-1:0]      p_used     = '0;
  bit                                   p_overflow = 1'b0;

  aip_pkg::res_t pending_results[$];
  int unsigned   mismatches   = 0;
  int unsigned   parsed_chars = 0;  // characters the parser actually looks at
  bit            steady       = 1'b0; // no idling on either side while set

  function automatic int unsigned char_weight(input char_t c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 255;
  endfunction

  function automatic void bump_used();
    if (p_used != aip_pkg::OFFSET_MAX) p_used++;
  endfunction

  // Advance the mirror by one character; returns 1 when it ends the string.
  function automatic bit parse_char(input char_t c, input bit s,
                                    output aip_pkg::res_t r);
    int unsigned      w;
    logic [63:0]      mac;
    r = '0;
    if (s) begin
      p_phase    = aip_pkg::PH_LEAD;
      p_acc      = '0;
      p_negative = 1'b0;
      p_radix    = radix_reg;
      p_used     = '0;
      p_overflow = 1'b0;
    end
    if (p_phase == aip_pkg::PH_DONE) return 1'b0;

    if (p_phase == aip_pkg::PH_LEAD) begin
      if (c == aip_pkg::CH_SPACE || c == aip_pkg::CH_TAB) begin
        bump_used();
        return 1'b0;
      end
      p_phase = aip_pkg::PH_SIGNED;
      if (c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS) begin
        p_negative = (c == aip_pkg::CH_MINUS);
        bump_used();
        return 1'b0;
      end
    end

    if (p_phase == aip_pkg::PH_SIGNED) begin
      if ((p_radix == aip_pkg::BASE_AUTO || p_radix == aip_pkg::BASE_HEX) &&
          c == aip_pkg::CH_ZERO) begin
        bump_used();
        p_phase = aip_pkg::PH_ZERO;
        return 1'b0;
      end
      if (p_radix == aip_pkg::BASE_AUTO) p_radix = aip_pkg::BASE_TEN;
      p_phase = aip_pkg::PH_DIGITS;
    end else if (p_phase == aip_pkg::PH_ZERO) begin
      // a lone zero is a digit of value zero unless an x follows
      p_phase = aip_pkg::PH_DIGITS;
      if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
        p_radix = aip_pkg::BASE_HEX;
        bump_used();
        return 1'b0;
      end
      if (p_radix == aip_pkg::BASE_AUTO) p_radix = aip_pkg::BASE_TEN;
    end

    w = char_weight(c);
    if (w < p_radix) begin
      mac = 64'(p_acc) * 64'(p_radix) + 64'(w);
      if (mac[63:aip_pkg::VALUE_BITS] != '0) p_overflow = 1'b1;
      p_acc = mac[aip_pkg::VALUE_BITS-1:0];
      bump_used();
      return 1'b0;
    end

    // stopping character: negation wraps silently, only magnitude overflow flags
    r.value      = p_negative ? -p_acc : p_acc;
    r.end_offset = p_used;
    r.wrapped    = p_overflow;
    p_phase      = aip_pkg::PH_DONE;
    return 1'b1;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  int unsigned ready_hold = 0;

  always @(posedge clk_i) begin
    if (steady) begin
      out_ready_i <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready_i <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b0;
      ready_hold = idle_len();
    end
  end

  always @(posedge clk_i) begin : result_check
    aip_pkg::res_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result value=%0d offset=%0d wrapped=%0b",
                 $time, value_o, end_offset_o, wrapped_o);
      end else begin
        head = pending_results.pop_front();
        if (value_o !== head.value) begin
          mismatches++;
          $display("%0t: value expected %0d actual %0d",
                   $time, $signed(head.value), value_o);
        end
        if (end_offset_o !== head.end_offset) begin
          mismatches++;
          $display("%0t: end_offset expected %0d actual %0d",
                   $time, head.end_offset, end_offset_o);
        end
        if (wrapped_o !== head.wrapped) begin
          mismatches++;
          $display("%0t: wrapped expected %0b actual %0b",
                   $time, head.wrapped, wrapped_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character side. Every task is entered and left at a rising edge.
  // ---------------------------------------------------------------------------

  // One character transaction. Valid stays up across back-to-back transactions.
  task automatic push_char(input char_t c, input bit s,
                           input int unsigned gap,
                           input bit typed = 1'b0, input aip_pkg::res_t want = '0);
    aip_pkg::res_t got;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    character_i       <= c;
    start_of_string_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (s || p_phase != aip_pkg::PH_DONE) parsed_chars++;
    if (parse_char(c, s, got)) pending_results.push_back(typed ? want : got);
  endtask

  // Hold off until every result is back, then let the pipe empty out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_radix(input radix_t b);
    cfg_valid_i   <= 1'b1;
    number_base_i <= b;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    radix_reg = b;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic char_t digit_char(input int unsigned w);
    if (w < 10) return aip_pkg::CH_ZERO + char_t'(w);
    return ($urandom_range(0, 1) ? aip_pkg::CH_LA : aip_pkg::CH_UA) + char_t'(w - 10);
  endfunction

  // One string: mostly well formed (blanks, sign, prefix, digits, stopper),
  // sometimes plain noise with random restarts.
  task automatic send_string(input bit long_lead);
    char_t                text[$];
    int unsigned          n;
    int unsigned          lim;
    int unsigned          span;
    bit                   hex;
    if (!long_lead && $urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      repeat (n)
        push_char(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idle_len());
      return;
    end
    // long blank runs push the offset into saturation
    n = long_lead ? $urandom_range(250, 270)
                  : ($urandom_range(0, 9) < 3 ? $urandom_range(1, 3) : 0);
    repeat (n) text.push_back($urandom_range(0, 1) ? aip_pkg::CH_SPACE : aip_pkg::CH_TAB);
    if ($urandom_range(0, 1))
      text.push_back($urandom_range(0, 1) ? aip_pkg::CH_MINUS : aip_pkg::CH_PLUS);
    hex = (radix_reg == aip_pkg::BASE_AUTO || radix_reg == aip_pkg::BASE_HEX)
            ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
    if (hex) begin
      text.push_back(aip_pkg::CH_ZERO);
      text.push_back($urandom_range(0, 1) ? aip_pkg::CH_LX : aip_pkg::CH_UX);
    end
    lim = (radix_reg == aip_pkg::BASE_AUTO) ? (hex ? 16 : 10) : radix_reg;
    if (lim > 36) lim = 36;
    case ($urandom_range(0, 9))
      0:       span = 0;
      1, 2:    span = $urandom_range(9, 14);   // long runs of high digits to overflow
      default: span = $urandom_range(1, 8);
    endcase
    repeat (span)
      text.push_back(digit_char(span > 8 ? $urandom_range(lim / 2, lim - 1)
                                         : $urandom_range(0, lim - 1)));
    case ($urandom_range(0, 3))
      0:       text.push_back(8'h00);
      1:       text.push_back(aip_pkg::CH_SPACE);
      2:       text.push_back(",");
      default: text.push_back(char_t'($urandom_range(0, 255)));
    endcase
    // trailing bytes without a start flag should be dropped by the block
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) text.push_back(char_t'($urandom_range(0, 255)));
    end
    foreach (text[k]) push_char(text[k], k == 0, idle_len());
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. Rows that set the base carry it in ch.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit            set_radix;
    char_t         ch;
    bit            st;
    bit            typed;
    aip_pkg::res_t want;
  } script_row_t;

  script_row_t script[27] = '{
    '{1'b0, "x",               1'b0, 1'b0, '0},             // ignored, no parse open
    '{1'b0, aip_pkg::CH_SPACE, 1'b1, 1'b0, '0},
    '{1'b0, aip_pkg::CH_TAB,   1'b0, 1'b0, '0},
    '{1'b0, aip_pkg::CH_MINUS, 1'b0, 1'b0, '0},
    '{1'b0, "7",               1'b0, 1'b0, '0},
    '{1'b0, 8'h00,             1'b0, 1'b1, '{-32'sd7, 8'd4, 1'b0}}, // terminator
    '{1'b0, aip_pkg::CH_PLUS,  1'b1, 1'b0, '0},
    '{1'b0, 8'hFF,             1'b0, 1'b1, '{32'd0, 8'd1, 1'b0}},   // sign, no digits
    '{1'b0, "4",               1'b1, 1'b0, '0},
    '{1'b0, "5",               1'b1, 1'b0, '0},             // restart drops the 4
    '{1'b0, "/",               1'b0, 1'b1, '{32'd5, 8'd1, 1'b0}},
    '{1'b1, 8'd16,             1'b0, 1'b0, '0},
    '{1'b0, aip_pkg::CH_ZERO,  1'b1, 1'b0, '0},
    '{1'b0, aip_pkg::CH_UX,    1'b0, 1'b0, '0},
    '{1'b0, "f",               1'b0, 1'b0, '0},
    '{1'b0, "g",               1'b0, 1'b1, '{32'd15, 8'd3, 1'b0}},
    '{1'b0, aip_pkg::CH_ZERO,  1'b1, 1'b0, '0},
    '{1'b0, "z",               1'b0, 1'b1, '{32'd0, 8'd1, 1'b0}},   // zero, then no x
    '{1'b1, 8'd63,             1'b0, 1'b0, '0},             // every letter is a digit
    '{1'b0, aip_pkg::CH_MINUS, 1'b1, 1'b0, '0},
    '{1'b0, "z",               1'b0, 1'b0, '0},
    '{1'b0, "Z",               1'b0, 1'b0, '0},
    '{1'b0, "z",               1'b0, 1'b0, '0},
    '{1'b0, "Z",               1'b0, 1'b0, '0},
    '{1'b0, "z",               1'b0, 1'b0, '0},
    '{1'b0, "z",               1'b0, 1'b0, '0},             // magnitude overflows here
    '{1'b0, ".",               1'b0, 1'b0, '0}
  };

  initial begin : stimulus
    radix_t               radix_plan[10];
    int unsigned          goal;
    radix_plan = '{aip_pkg::BASE_AUTO, aip_pkg::BASE_HEX, aip_pkg::BASE_TEN,
                   6'd1, 6'd36, 6'd63, 6'd2, 6'd8,
                   radix_t'($urandom_range(3, 35)), radix_t'($urandom_range(37, 62))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].set_radix) begin
        drain();
        write_radix(radix_t'(script[i].ch));
      end else begin
        push_char(script[i].ch, script[i].st, idle_len(), script[i].typed, script[i].want);
      end
    end

    // random phases, one base each; phase three runs with no random gaps or stalls
    foreach (radix_plan[p]) begin
      drain();
      steady = (p == 3);
      write_radix(radix_plan[p]);
      goal = parsed_chars + 120;
      if (p == 2) send_string(1'b1);
      while (parsed_chars < goal) begin
        send_string($urandom_range(0, 79) == 0);
        if ($urandom_range(0, 39) == 0) drain();
      end
      // close any open string so the block is idle before the next base
      push_char(8'h00, 1'b1, idle_len());
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ascii_integer_parser regression: pass");
    end else begin
      $display("ascii_integer_parser regression: fail");
    end
    $finish;
  end

endmodule
